// ===== rtl/sst_pkg.sv =====
// shared types, constants and codes of the sparse set slot table
package sst_pkg;

   localparam int MAX_ENTITIES  = 256;
   localparam int MAX_SLOTS     = 256;
   localparam int PAYLOAD_WIDTH = 32;

   localparam int ENT_W  = $clog2(MAX_ENTITIES);
   localparam int SLOT_W = $clog2(MAX_SLOTS);
   localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
   localparam int CFG_W  = 9;
   localparam int FUNC_W = 3;
   localparam int STAT_W = 2;
   localparam int CSR_IDX_W = 1;

   // operation codes
   localparam logic [FUNC_W-1:0] FN_ASSIGN    = 3'd0;
   localparam logic [FUNC_W-1:0] FN_REMOVE    = 3'd1;
   localparam logic [FUNC_W-1:0] FN_ENT_OF_SL = 3'd2;
   localparam logic [FUNC_W-1:0] FN_SL_OF_ENT = 3'd3;
   localparam logic [FUNC_W-1:0] FN_RENAME    = 3'd4;
   localparam logic [FUNC_W-1:0] FN_READ      = 3'd5;
   localparam logic [FUNC_W-1:0] FN_WRITE     = 3'd6;
   localparam logic [FUNC_W-1:0] FN_CLEAR     = 3'd7;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
   localparam logic [STAT_W-1:0] ST_NOMAP = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ENTITY_LIMIT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_LIMIT   = 1'b1;

   localparam logic [CFG_W-1:0] ENTITY_LIMIT_RESET = 9'd256;
   localparam logic [CFG_W-1:0] SLOT_LIMIT_RESET   = 9'd256;

   typedef struct packed {
      logic [FUNC_W-1:0]        func;
      logic [ENT_W-1:0]         entity_id;
      logic [ENT_W-1:0]         new_entity_id;
      logic [SLOT_W-1:0]        slot_id;
      logic [PAYLOAD_WIDTH-1:0] data_in;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0]        status;
      logic [SLOT_W-1:0]        slot_out;
      logic [ENT_W-1:0]         entity_out;
      logic [PAYLOAD_WIDTH-1:0] data_out;
   } rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } cmd_type;

   typedef struct packed {
      logic rsp_free;
   } dp_status_type;

endpackage

// ===== rtl/sparse_set_slot_table.sv =====
// Sparse set slot table: packed slots with payload, owner map and entity map.
// Request channel (req_valid/req_ready/req_payload) carries one operation:
// assign, remove (swap-and-pop), entity of slot, slot of entity, rename,
// read, write or clear. Each request gives exactly one response on the
// rsp_valid/rsp_ready/rsp_payload channel, with a status code.
// Limits are set through the write-only csr_ port (index 0 entity limit,
// index 1 slot limit); the user sets them only while no request is in flight, unenforced.
// The accepting edge also reads the maps and payload store into registers; the
// execute step that follows (all map and payload writes) loads the response
// register and raises rsp_valid, but waits while the previous response is
// still held there. A new request is taken only after the previous one has
// executed.
// Reset (synchronous) empties the table: every entity is unmapped, the
// occupancy count is zero and both limits are 256. There is no clearing pass.
// When the receiver stalls, the response waits in the output register; the
// next request is still taken, then held until that response is taken.
module sparse_set_slot_table (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  sst_pkg::req_type              req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output sst_pkg::rsp_type              rsp_payload,
   input  logic                          csr_we,
   input  logic [sst_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sst_pkg::CFG_W-1:0]     csr_wdata
);

   sst_pkg::cmd_type       cmd;
   sst_pkg::dp_status_type dp_status;

   sst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   sst_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req       (req_payload),
      .cmd       (cmd),
      .dp_status (dp_status),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp       (rsp_payload),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready)
   );

   // one request at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in flight");

   // a failed operation reports no slot, entity or data
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status != sst_pkg::ST_OK) |->
         (rsp_payload.slot_out == '0) && (rsp_payload.entity_out == '0) &&
         (rsp_payload.data_out == '0))
      else $error("error response carries nonzero fields");

   // a new response only follows an execute step
   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.execute))
      else $error("response appeared without an execute step");

   // capture and execute never overlap
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cmd.capture && cmd.execute))
      else $error("capture and execute in the same cycle");

endmodule

// ===== rtl/sst_ctrl.sv =====
// controller state machine: request capture and execute sequencing
module sst_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  sst_pkg::dp_status_type dp_status,
   output sst_pkg::cmd_type      cmd
);

   sst_pkg::state_type state_ff;
   sst_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sst_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sst_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = sst_pkg::ST_EXEC;
            end
         end
         sst_pkg::ST_EXEC: begin
            if (dp_status.rsp_free) begin
               state_in = sst_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sst_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      case (state_ff)
         sst_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         sst_pkg::ST_EXEC: begin
            // hold while the previous response still sits in the output register
            cmd.execute = dp_status.rsp_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// ===== rtl/sst_datapath.sv =====
// datapath: maps, payload store, occupancy count, limits and response register
module sst_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sst_pkg::req_type                     req,
   input  sst_pkg::cmd_type                     cmd,
   output sst_pkg::dp_status_type               dp_status,
   input  logic                                 csr_we,
   input  logic [sst_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [sst_pkg::CFG_W-1:0]            csr_wdata,
   output sst_pkg::rsp_type                     rsp,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready
);

   localparam int ENT_W  = sst_pkg::ENT_W;
   localparam int SLOT_W = sst_pkg::SLOT_W;
   localparam int CNT_W  = sst_pkg::CNT_W;
   localparam int PW     = sst_pkg::PAYLOAD_WIDTH;

   // memories
   logic [SLOT_W-1:0] e2s_mem_ff [sst_pkg::MAX_ENTITIES];
   logic [ENT_W-1:0]  s2e_mem_ff [sst_pkg::MAX_SLOTS];
   logic [PW-1:0]     pay_mem_ff [sst_pkg::MAX_SLOTS];

   // registered read data
   logic [SLOT_W-1:0] e2s_a_ff;
   logic [ENT_W-1:0]  s2e_slot_ff;
   logic [ENT_W-1:0]  s2e_last_ff;
   logic [PW-1:0]     pay_slot_ff;
   logic [PW-1:0]     pay_last_ff;

   sst_pkg::req_type  req_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [sst_pkg::CFG_W-1:0] entity_limit_ff;
   logic [sst_pkg::CFG_W-1:0] slot_limit_ff;
   logic [sst_pkg::MAX_ENTITIES-1:0] e2s_vld_ff;
   logic [sst_pkg::MAX_ENTITIES-1:0] e2s_vld_in;
   logic              rsp_valid_ff;
   sst_pkg::rsp_type  rsp_ff;
   sst_pkg::rsp_type  rsp_in;

   logic              e2s_we;
   logic [ENT_W-1:0]  e2s_waddr;
   logic [SLOT_W-1:0] e2s_wdata;
   logic              s2e_we;
   logic [SLOT_W-1:0] s2e_waddr;
   logic [ENT_W-1:0]  s2e_wdata;
   logic              pay_we;
   logic [SLOT_W-1:0] pay_waddr;
   logic [PW-1:0]     pay_wdata;

   logic [SLOT_W-1:0] last_idx;
   logic              slot_ok;
   logic              ent_ok;
   logic              nent_ok;
   logic              ent_mapped;
   logic              nent_mapped;
   logic              full;

   assign last_idx = count_ff[SLOT_W-1:0] - SLOT_W'(1);
   assign dp_status.rsp_free = !rsp_valid_ff || rsp_ready;
   assign rsp       = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   // reads are taken at request capture; the slot map and payload store also read the last slot
   always_ff @(posedge clock) begin
      if (cmd.execute && e2s_we) begin
         e2s_mem_ff[e2s_waddr] <= e2s_wdata;
      end
      if (cmd.capture) begin
         e2s_a_ff <= e2s_mem_ff[req.entity_id];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute && s2e_we) begin
         s2e_mem_ff[s2e_waddr] <= s2e_wdata;
      end
      if (cmd.capture) begin
         s2e_slot_ff <= s2e_mem_ff[req.slot_id];
         s2e_last_ff <= s2e_mem_ff[last_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute && pay_we) begin
         pay_mem_ff[pay_waddr] <= pay_wdata;
      end
      if (cmd.capture) begin
         pay_slot_ff <= pay_mem_ff[req.slot_id];
         pay_last_ff <= pay_mem_ff[last_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req;
      end
      if (cmd.execute) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff        <= '0;
         e2s_vld_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
         entity_limit_ff <= sst_pkg::ENTITY_LIMIT_RESET;
         slot_limit_ff   <= sst_pkg::SLOT_LIMIT_RESET;
      end else begin
         if (cmd.execute) begin
            count_ff     <= count_in;
            e2s_vld_ff   <= e2s_vld_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            case (csr_index)
               sst_pkg::CSR_ENTITY_LIMIT: entity_limit_ff <= csr_wdata;
               sst_pkg::CSR_SLOT_LIMIT:   slot_limit_ff   <= csr_wdata;
               default: begin
                  entity_limit_ff <= entity_limit_ff;
               end
            endcase
         end
      end
   end

   assign slot_ok     = {1'b0, req_ff.slot_id} < count_ff;
   assign ent_ok      = {1'b0, req_ff.entity_id} < entity_limit_ff;
   assign nent_ok     = {1'b0, req_ff.new_entity_id} < entity_limit_ff;
   assign ent_mapped  = e2s_vld_ff[req_ff.entity_id];
   assign nent_mapped = e2s_vld_ff[req_ff.new_entity_id];
   assign full        = (count_ff >= slot_limit_ff) ||
                        (count_ff >= CNT_W'(sst_pkg::MAX_SLOTS));

   always_comb begin
      rsp_in     = '0;
      count_in   = count_ff;
      e2s_vld_in = e2s_vld_ff;
      e2s_we     = 1'b0;
      e2s_waddr  = req_ff.entity_id;
      e2s_wdata  = count_ff[SLOT_W-1:0];
      s2e_we     = 1'b0;
      s2e_waddr  = req_ff.slot_id;
      s2e_wdata  = req_ff.entity_id;
      pay_we     = 1'b0;
      pay_waddr  = req_ff.slot_id;
      pay_wdata  = req_ff.data_in;
      case (req_ff.func)
         sst_pkg::FN_ASSIGN: begin
            if (!ent_ok) begin
               rsp_in.status = sst_pkg::ST_RANGE;
            end else if (ent_mapped) begin
               rsp_in.slot_out   = e2s_a_ff;
               rsp_in.entity_out = req_ff.entity_id;
            end else if (full) begin
               rsp_in.status = sst_pkg::ST_FULL;
            end else begin
               // append at the end of the packed range
               rsp_in.slot_out   = count_ff[SLOT_W-1:0];
               rsp_in.entity_out = req_ff.entity_id;
               s2e_we    = 1'b1;
               s2e_waddr = count_ff[SLOT_W-1:0];
               s2e_wdata = req_ff.entity_id;
               e2s_we    = 1'b1;
               e2s_waddr = req_ff.entity_id;
               e2s_wdata = count_ff[SLOT_W-1:0];
               e2s_vld_in[req_ff.entity_id] = 1'b1;
               count_in  = count_ff + CNT_W'(1);
            end
         end
         sst_pkg::FN_REMOVE: begin
            if (!slot_ok) begin
               rsp_in.status = sst_pkg::ST_RANGE;
            end else begin
               rsp_in.slot_out   = req_ff.slot_id;
               rsp_in.entity_out = s2e_slot_ff;
               e2s_vld_in[s2e_slot_ff] = 1'b0;
               // swap-and-pop: last slot moves into the hole
               if (req_ff.slot_id != last_idx) begin
                  pay_we    = 1'b1;
                  pay_waddr = req_ff.slot_id;
                  pay_wdata = pay_last_ff;
                  s2e_we    = 1'b1;
                  s2e_waddr = req_ff.slot_id;
                  s2e_wdata = s2e_last_ff;
                  e2s_we    = 1'b1;
                  e2s_waddr = s2e_last_ff;
                  e2s_wdata = req_ff.slot_id;
                  e2s_vld_in[s2e_last_ff] = 1'b1;
               end
               count_in = count_ff - CNT_W'(1);
            end
         end
         sst_pkg::FN_ENT_OF_SL: begin
            if (!slot_ok) begin
               rsp_in.status = sst_pkg::ST_RANGE;
            end else begin
               rsp_in.slot_out   = req_ff.slot_id;
               rsp_in.entity_out = s2e_slot_ff;
            end
         end
         sst_pkg::FN_SL_OF_ENT: begin
            if (!ent_ok) begin
               rsp_in.status = sst_pkg::ST_RANGE;
            end else if (!ent_mapped) begin
               rsp_in.status = sst_pkg::ST_NOMAP;
            end else begin
               rsp_in.slot_out   = e2s_a_ff;
               rsp_in.entity_out = req_ff.entity_id;
            end
         end
         sst_pkg::FN_RENAME: begin
            if (!ent_ok || !nent_ok) begin
               rsp_in.status = sst_pkg::ST_RANGE;
            end else if (!ent_mapped) begin
               rsp_in.status = sst_pkg::ST_NOMAP;
            end else if ((req_ff.new_entity_id != req_ff.entity_id) && nent_mapped) begin
               rsp_in.status = sst_pkg::ST_FULL;
            end else begin
               rsp_in.slot_out   = e2s_a_ff;
               rsp_in.entity_out = req_ff.new_entity_id;
               // clear old then set new, so a rename to itself keeps the mapping
               e2s_vld_in[req_ff.entity_id]     = 1'b0;
               e2s_vld_in[req_ff.new_entity_id] = 1'b1;
               e2s_we    = 1'b1;
               e2s_waddr = req_ff.new_entity_id;
               e2s_wdata = e2s_a_ff;
               s2e_we    = 1'b1;
               s2e_waddr = e2s_a_ff;
               s2e_wdata = req_ff.new_entity_id;
            end
         end
         default: begin
            if (!slot_ok) begin
               rsp_in.status = sst_pkg::ST_RANGE;
            end else begin
               rsp_in.slot_out   = req_ff.slot_id;
               rsp_in.entity_out = s2e_slot_ff;
               if (req_ff.func == sst_pkg::FN_READ) begin
                  rsp_in.data_out = pay_slot_ff;
               end else if (req_ff.func == sst_pkg::FN_WRITE) begin
                  pay_we    = 1'b1;
                  pay_wdata = req_ff.data_in;
               end else if (req_ff.func == sst_pkg::FN_CLEAR) begin
                  pay_we    = 1'b1;
                  pay_wdata = '0;
               end
            end
         end
      endcase
   end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// testbench of the sparse set slot table: directed and random requests, checked against a model

class slot_table_scoreboard;
   localparam logic [sst_pkg::SLOT_W:0] UNMAPPED = '1;

   logic [sst_pkg::SLOT_W:0]        entity_slot [sst_pkg::MAX_ENTITIES];
   logic [sst_pkg::ENT_W:0]         slot_owner [sst_pkg::MAX_SLOTS];
   logic [sst_pkg::PAYLOAD_WIDTH-1:0] payload [sst_pkg::MAX_SLOTS];
   bit                     payload_known [sst_pkg::MAX_SLOTS];
   int                     occupied;
   logic [sst_pkg::CFG_W-1:0]       entity_limit;
   logic [sst_pkg::CFG_W-1:0]       slot_limit;
   sst_pkg::rsp_type       expected_answers [$];
   int                     errors;

   function new();
      entity_limit = sst_pkg::ENTITY_LIMIT_RESET;
      slot_limit = sst_pkg::SLOT_LIMIT_RESET;
      foreach (entity_slot[i]) entity_slot[i] = UNMAPPED;
      foreach (slot_owner[i]) slot_owner[i] = '1;
      foreach (payload_known[i]) payload_known[i] = 1'b0;
      occupied = 0;
      errors = 0;
   endfunction

   function int entity_cap();
      return (entity_limit < sst_pkg::MAX_ENTITIES) ? int'(entity_limit) : sst_pkg::MAX_ENTITIES;
   endfunction

   function int slot_cap();
      return (slot_limit < sst_pkg::MAX_SLOTS) ? int'(slot_limit) : sst_pkg::MAX_SLOTS;
   endfunction

   function void set_limit(logic [sst_pkg::CSR_IDX_W-1:0] idx,
                           logic [sst_pkg::CFG_W-1:0] value);
      if (idx == sst_pkg::CSR_ENTITY_LIMIT) begin
         entity_limit = value;
      end else if (idx == sst_pkg::CSR_SLOT_LIMIT) begin
         slot_limit = value;
      end
   endfunction

   // apply one accepted request to the table copy and queue the answer it gives
   function void take_request(sst_pkg::req_type q);
      sst_pkg::rsp_type         a;
      logic [sst_pkg::ENT_W:0]  gone;
      logic [sst_pkg::ENT_W:0]  mover;
      logic [sst_pkg::SLOT_W:0] s;
      int              last;
      bit              slot_ok;
      bit              ent_ok;
      a = '0;
      slot_ok = q.slot_id < occupied;
      ent_ok = q.entity_id < entity_cap();
      case (q.func)
         sst_pkg::FN_ASSIGN: begin
            if (!ent_ok) begin
               a.status = sst_pkg::ST_RANGE;
            end else if (entity_slot[q.entity_id] != UNMAPPED) begin
               a.slot_out = entity_slot[q.entity_id][sst_pkg::SLOT_W-1:0];
               a.entity_out = q.entity_id;
            end else if (occupied >= slot_cap()) begin
               a.status = sst_pkg::ST_FULL;
            end else begin
               a.slot_out = sst_pkg::SLOT_W'(occupied);
               slot_owner[occupied] = {1'b0, q.entity_id};
               entity_slot[q.entity_id] = (sst_pkg::SLOT_W + 1)'(occupied);
               occupied++;
               a.entity_out = q.entity_id;
            end
         end
         sst_pkg::FN_REMOVE: begin
            if (!slot_ok) begin
               a.status = sst_pkg::ST_RANGE;
            end else begin
               last = occupied - 1;
               gone = slot_owner[q.slot_id];
               if (gone < sst_pkg::MAX_ENTITIES)
                  entity_slot[gone[sst_pkg::ENT_W-1:0]] = UNMAPPED;
               // swap-and-pop: the last slot fills the hole
               if (q.slot_id != last) begin
                  mover = slot_owner[last];
                  payload[q.slot_id] = payload[last];
                  payload_known[q.slot_id] = payload_known[last];
                  slot_owner[q.slot_id] = mover;
                  if (mover < sst_pkg::MAX_ENTITIES)
                     entity_slot[mover[sst_pkg::ENT_W-1:0]] = {1'b0, q.slot_id};
               end
               slot_owner[last] = '1;
               occupied = last;
               a.slot_out = q.slot_id;
               a.entity_out = gone[sst_pkg::ENT_W-1:0];
            end
         end
         sst_pkg::FN_ENT_OF_SL: begin
            if (!slot_ok) begin
               a.status = sst_pkg::ST_RANGE;
            end else begin
               a.slot_out = q.slot_id;
               a.entity_out = slot_owner[q.slot_id][sst_pkg::ENT_W-1:0];
            end
         end
         sst_pkg::FN_SL_OF_ENT: begin
            if (!ent_ok) begin
               a.status = sst_pkg::ST_RANGE;
            end else if (entity_slot[q.entity_id] == UNMAPPED) begin
               a.status = sst_pkg::ST_NOMAP;
            end else begin
               a.slot_out = entity_slot[q.entity_id][sst_pkg::SLOT_W-1:0];
               a.entity_out = q.entity_id;
            end
         end
         sst_pkg::FN_RENAME: begin
            if (!ent_ok || q.new_entity_id >= entity_cap()) begin
               a.status = sst_pkg::ST_RANGE;
            end else if (entity_slot[q.entity_id] == UNMAPPED) begin
               a.status = sst_pkg::ST_NOMAP;
            end else if (q.new_entity_id != q.entity_id &&
                         entity_slot[q.new_entity_id] != UNMAPPED) begin
               a.status = sst_pkg::ST_FULL;
            end else begin
               s = entity_slot[q.entity_id];
               entity_slot[q.entity_id] = UNMAPPED;
               entity_slot[q.new_entity_id] = s;
               if (s < sst_pkg::MAX_SLOTS)
                  slot_owner[s[sst_pkg::SLOT_W-1:0]] = {1'b0, q.new_entity_id};
               a.slot_out = s[sst_pkg::SLOT_W-1:0];
               a.entity_out = q.new_entity_id;
            end
         end
         default: begin
            if (!slot_ok) begin
               a.status = sst_pkg::ST_RANGE;
            end else begin
               a.slot_out = q.slot_id;
               a.entity_out = slot_owner[q.slot_id][sst_pkg::ENT_W-1:0];
               if (q.func == sst_pkg::FN_READ) begin
                  a.data_out = payload[q.slot_id];
               end else if (q.func == sst_pkg::FN_WRITE) begin
                  payload[q.slot_id] = q.data_in;
                  payload_known[q.slot_id] = 1'b1;
               end else begin
                  payload[q.slot_id] = '0;
                  payload_known[q.slot_id] = 1'b1;
               end
            end
         end
      endcase
      expected_answers.push_back(a);
   endfunction

   function void check_response(sst_pkg::rsp_type got);
      sst_pkg::rsp_type want;
      if (expected_answers.size() == 0) begin
         $error("response with no request outstanding: %h", got);
         errors++;
         return;
      end
      want = expected_answers.pop_front();
      if (got.status !== want.status) begin
         $error("status: expected %0d, got %0d", want.status, got.status);
         errors++;
      end
      if (got.slot_out !== want.slot_out) begin
         $error("slot_out: expected %0d, got %0d", want.slot_out, got.slot_out);
         errors++;
      end
      if (got.entity_out !== want.entity_out) begin
         $error("entity_out: expected %0d, got %0d", want.entity_out, got.entity_out);
         errors++;
      end
      if (got.data_out !== want.data_out) begin
         $error("data_out: expected %h, got %h", want.data_out, got.data_out);
         errors++;
      end
   endfunction
endclass

module testbench;
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   sst_pkg::req_type     req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   sst_pkg::rsp_type     rsp_payload;
   logic                 csr_we = 1'b0;
   logic [sst_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [sst_pkg::CFG_W-1:0]     csr_wdata = '0;

   slot_table_scoreboard sb = new();
   bit tx_steady = 1'b0;

   sparse_set_slot_table uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic sst_pkg::req_type op(logic [sst_pkg::FUNC_W-1:0] f,
                                           logic [sst_pkg::ENT_W-1:0] e,
                                           logic [sst_pkg::ENT_W-1:0] ne,
                                           logic [sst_pkg::SLOT_W-1:0] s,
                                           logic [sst_pkg::PAYLOAD_WIDTH-1:0] d);
      sst_pkg::req_type q;
      q.func = f;
      q.entity_id = e;
      q.new_entity_id = ne;
      q.slot_id = s;
      q.data_in = d;
      return q;
   endfunction

   // mostly ids under the limit or current owners, so lookups and renames hit
   function automatic logic [sst_pkg::ENT_W-1:0] pick_entity();
      int lim;
      int r;
      lim = sb.entity_cap();
      r = $urandom_range(0, 9);
      if (r < 2 || lim == 0)
         return sst_pkg::ENT_W'($urandom_range(0, sst_pkg::MAX_ENTITIES - 1));
      if (r < 5 && sb.occupied != 0)
         return sb.slot_owner[$urandom_range(0, sb.occupied - 1)][sst_pkg::ENT_W-1:0];
      return sst_pkg::ENT_W'($urandom_range(0, lim - 1));
   endfunction

   function automatic logic [sst_pkg::SLOT_W-1:0] pick_slot();
      if (sb.occupied == 0 || $urandom_range(0, 7) == 0)
         return sst_pkg::SLOT_W'($urandom_range(0, sst_pkg::MAX_SLOTS - 1));
      return sst_pkg::SLOT_W'($urandom_range(0, sb.occupied - 1));
   endfunction

   function automatic sst_pkg::req_type make_item();
      sst_pkg::req_type q;
      int r;
      q.entity_id = pick_entity();
      q.new_entity_id = pick_entity();
      q.slot_id = pick_slot();
      r = $urandom_range(0, 9);
      q.data_in = (r == 0) ? '0 : (r == 1) ? '1 : sst_pkg::PAYLOAD_WIDTH'($urandom);
      r = $urandom_range(0, 99);
      if (r < 25) q.func = sst_pkg::FN_ASSIGN;
      else if (r < 37) q.func = sst_pkg::FN_REMOVE;
      else if (r < 45) q.func = sst_pkg::FN_ENT_OF_SL;
      else if (r < 55) q.func = sst_pkg::FN_SL_OF_ENT;
      else if (r < 63) q.func = sst_pkg::FN_RENAME;
      else if (r < 78) q.func = sst_pkg::FN_READ;
      else if (r < 93) q.func = sst_pkg::FN_WRITE;
      else q.func = sst_pkg::FN_CLEAR;
      // never read a payload that was never written
      if (q.func == sst_pkg::FN_READ && q.slot_id < sb.occupied &&
          !sb.payload_known[q.slot_id])
         q.func = sst_pkg::FN_WRITE;
      return q;
   endfunction

   task automatic send_request(input sst_pkg::req_type q);
      int gap;
      if ($urandom_range(0, 29) == 0) tx_steady = !tx_steady;
      gap = tx_steady ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= q;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.take_request(q);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_answers.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(input logic [sst_pkg::CSR_IDX_W-1:0] idx,
                              input logic [sst_pkg::CFG_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_limit(idx, value);
   endtask

   task automatic run_phase(input logic [sst_pkg::CFG_W-1:0] ent_lim,
                            input logic [sst_pkg::CFG_W-1:0] slot_lim,
                            input int n);
      drain();
      write_limit(sst_pkg::CSR_ENTITY_LIMIT, ent_lim);
      write_limit(sst_pkg::CSR_SLOT_LIMIT, slot_lim);
      repeat (n) send_request(make_item());
   endtask

   initial begin : stimulus
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      write_limit(sst_pkg::CSR_ENTITY_LIMIT, 9'd256);
      write_limit(sst_pkg::CSR_SLOT_LIMIT, 9'd3);

      send_request(op(sst_pkg::FN_READ,      8'd0,   8'd0,   8'd0,   '0));
      send_request(op(sst_pkg::FN_ASSIGN,    8'd0,   8'd0,   8'd0,   '0));
      send_request(op(sst_pkg::FN_ASSIGN,    8'd255, 8'd0,   8'd0,   '0));
      // already assigned: same slot back
      send_request(op(sst_pkg::FN_ASSIGN,    8'd0,   8'd0,   8'd0,   '0));
      send_request(op(sst_pkg::FN_ASSIGN,    8'd7,   8'd0,   8'd0,   '0));
      send_request(op(sst_pkg::FN_ASSIGN,    8'd9,   8'd0,   8'd0,   '0));
      send_request(op(sst_pkg::FN_WRITE,     8'd0,   8'd0,   8'd0,   32'hffff_ffff));
      send_request(op(sst_pkg::FN_WRITE,     8'd0,   8'd0,   8'd1,   32'h0));
      send_request(op(sst_pkg::FN_WRITE,     8'd0,   8'd0,   8'd2,   32'ha5a5_5a5a));
      send_request(op(sst_pkg::FN_READ,      8'd0,   8'd0,   8'd0,   '0));
      send_request(op(sst_pkg::FN_READ,      8'd0,   8'd0,   8'd255, '0));
      send_request(op(sst_pkg::FN_ENT_OF_SL, 8'd0,   8'd0,   8'd1,   '0));
      send_request(op(sst_pkg::FN_SL_OF_ENT, 8'd255, 8'd0,   8'd0,   '0));
      send_request(op(sst_pkg::FN_SL_OF_ENT, 8'd3,   8'd0,   8'd0,   '0));
      send_request(op(sst_pkg::FN_RENAME,    8'd3,   8'd4,   8'd0,   '0));
      send_request(op(sst_pkg::FN_RENAME,    8'd0,   8'd255, 8'd0,   '0));
      send_request(op(sst_pkg::FN_RENAME,    8'd0,   8'd0,   8'd0,   '0));
      send_request(op(sst_pkg::FN_RENAME,    8'd255, 8'd128, 8'd0,   '0));
      send_request(op(sst_pkg::FN_REMOVE,    8'd0,   8'd0,   8'd0,   '0));
      send_request(op(sst_pkg::FN_READ,      8'd0,   8'd0,   8'd0,   '0));
      send_request(op(sst_pkg::FN_SL_OF_ENT, 8'd0,   8'd0,   8'd0,   '0));
      send_request(op(sst_pkg::FN_CLEAR,     8'd0,   8'd0,   8'd1,   '0));
      send_request(op(sst_pkg::FN_READ,      8'd0,   8'd0,   8'd1,   '0));
      send_request(op(sst_pkg::FN_REMOVE,    8'd0,   8'd0,   8'd1,   '0));
      send_request(op(sst_pkg::FN_REMOVE,    8'd0,   8'd0,   8'd5,   '0));

      run_phase(9'd256, 9'd256, 80);
      run_phase(9'd16,  9'd8,   70);
      // slot limit below the current count
      run_phase(9'd16,  9'd2,   40);
      run_phase(9'd1,   9'd1,   40);
      run_phase(9'd0,   9'd0,   15);
      run_phase(9'd511, 9'd511, 70);
      run_phase(9'd256, 9'd1,   40);
      run_phase(9'd200, 9'd256, 80);
      run_phase(9'd40,  9'd64,  90);

      drain();
      if (sb.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin : response_side
      int  stall;
      int  taken;
      bit  steady;
      taken = 0;
      steady = 1'b0;
      forever begin
         if ($urandom_range(0, 29) == 0) steady = !steady;
         stall = steady ? 0 : $urandom_range(0, 14);
         // long hold-off so the block backs up and stops taking requests
         if (taken == 60 || taken == 330) stall = 150;
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         sb.check_response(rsp_payload);
         taken++;
      end
   end

   initial begin : watchdog
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end
endmodule
